FILE: src/gca_pkg.sv
// ----------------------------------------------------------------------------
// GPS C/A code generator package
// Shared types, constants and the G2 delay lookup of the C/A code generator.
// ----------------------------------------------------------------------------
package gca_pkg;

    localparam int C_CODE_LENGTH = 1023;
    localparam int C_REG_WIDTH   = 10;
    localparam int C_PRN_WIDTH   = 8;
    localparam int C_PRN_COUNT   = 210;

    typedef logic [C_REG_WIDTH-1:0] t_lfsr;
    typedef logic [C_PRN_WIDTH-1:0] t_prn;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_ALIGN
    } t_state;

    typedef struct packed {
        logic load;
        logic step_g2;
        logic emit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic aligned;
        logic count_zero;
        logic out_free;
    } t_dp_status;

    localparam logic [C_REG_WIDTH-1:0] C_G2_DELAY [C_PRN_COUNT] = '{
          5,   6,   7,   8,  17,  18, 139, 140, 141, 251,
        252, 254, 255, 256, 257, 258, 469, 470, 471, 472,
        473, 474, 509, 512, 513, 514, 515, 516, 859, 860,
        861, 862, 863, 950, 947, 948, 950,  67, 103,  91,
         19, 679, 225, 625, 946, 638, 161,1001, 554, 280,
        710, 709, 775, 864, 558, 220, 397,  55, 898, 759,
        367, 299,1018, 729, 695, 780, 801, 788, 732,  34,
        320, 327, 389, 407, 525, 405, 221, 761, 260, 326,
        955, 653, 699, 422, 188, 438, 959, 539, 879, 677,
        586, 153, 792, 814, 446, 264,1015, 278, 536, 819,
        156, 957, 159, 712, 885, 461, 248, 713, 126, 807,
        279, 122, 197, 693, 632, 771, 467, 647, 203, 145,
        175,  52,  21, 237, 235, 886, 657, 634, 762, 355,
       1012, 176, 603, 130, 359, 595,  68, 386, 797, 456,
        499, 883, 307, 127, 211, 121, 118, 163, 628, 853,
        484, 289, 811, 202,1021, 463, 568, 904, 670, 230,
        911, 684, 309, 644, 932,  12, 314, 891, 212, 185,
        675, 503, 150, 395, 345, 846, 798, 992, 357, 995,
        877, 112, 144, 476, 193, 109, 445, 291,  87, 399,
        292, 901, 339, 208, 711, 189, 263, 537, 663, 942,
        173, 900,  30, 500, 935, 556, 373,  85, 652, 310
    };

    // A PRN outside the table has no delay.
    function automatic t_lfsr g2_delay(input t_prn prn);
        t_lfsr delay;
        delay = '0;
        if (prn >= C_PRN_WIDTH'(1) && prn <= C_PRN_WIDTH'(C_PRN_COUNT)) begin
            delay = C_G2_DELAY[prn - C_PRN_WIDTH'(1)];
        end
        return delay;
    endfunction

endpackage

FILE: src/gps_ca_code_generator_core.sv
// A plain item gives its chip in the cycle after acceptance; one item per cycle while
// the output is free. A restart item, and the first item after reset, reloads both
// registers and then steps G2 once per cycle, CODE_LENGTH minus the PRN delay steps
// (none when the PRN has no delay), before its chip is registered once the output
// is free; no item is accepted meanwhile.
// Reset is synchronous and active low; the PRN register resets to 1.
// ----------------------------------------------------------------------------
// GPS C/A code generator core
// Streams the L1 C/A Gold code of the configured PRN, one chip per item.
// ----------------------------------------------------------------------------
module gps_ca_code_generator_core
    import gca_pkg::*;
#(
    parameter int CODE_LENGTH = C_CODE_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,      // prn_number
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [0] restart, [7:1] zero
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [0] chip, [7:1] zero
    output logic [0:0] m_axis_tuser      // [0] epoch_start
);

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    t_state     w_state;
    logic       w_chip;
    logic       w_epoch;

    gca_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_valid   (s_axis_tvalid),
        .i_s_restart (s_axis_tdata[0]),
        .i_status    (w_status),
        .o_s_ready   (s_axis_tready),
        .o_cmd       (w_cmd),
        .o_state     (w_state)
    );

    gca_datapath #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_cmd         (w_cmd),
        .i_m_ready     (m_axis_tready),
        .o_status      (w_status),
        .o_m_valid     (m_axis_tvalid),
        .o_chip        (w_chip),
        .o_epoch_start (w_epoch)
    );

    assign m_axis_tdata = {7'd0, w_chip};
    assign m_axis_tuser = w_epoch;

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_status.out_free)
        else $error("chip emitted while output item still pending");

    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step_g2 |-> !w_status.count_zero && w_state == ST_ALIGN)
        else $error("G2 stepped with alignment count exhausted");

    a_load_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !s_axis_tready && w_status.aligned)
        else $error("input taken during G2 alignment");
`endif

endmodule

FILE: src/gca_ctrl.sv
// ----------------------------------------------------------------------------
// GPS C/A code generator controller
// Accepts items and sequences the reload, G2 alignment and chip emission.
// ----------------------------------------------------------------------------
module gca_ctrl
    import gca_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_valid,
    input  logic       i_s_restart,
    input  t_dp_status i_status,
    output logic       o_s_ready,
    output t_ctrl_cmd  o_cmd,
    output t_state     o_state
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        o_s_ready = 1'b0;
        o_cmd     = '0;
        case (r_state)
            ST_RUN: begin
                o_s_ready = i_status.out_free;
                if (i_s_valid && i_status.out_free) begin
                    if (i_s_restart || !i_status.aligned) begin
                        o_cmd.load = 1'b1;
                        n_state    = ST_ALIGN;
                    end else begin
                        o_cmd.emit = 1'b1;
                    end
                end
            end
            ST_ALIGN: begin
                if (!i_status.count_zero) begin
                    o_cmd.step_g2 = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    assign o_state = r_state;

endmodule

FILE: src/gca_datapath.sv
// ----------------------------------------------------------------------------
// GPS C/A code generator datapath
// G1 and G2 shift registers, chip position, alignment counter and output item.
// ----------------------------------------------------------------------------
module gca_datapath
    import gca_pkg::*;
#(
    parameter int CODE_LENGTH = C_CODE_LENGTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  t_prn       i_cfg_wdata,
    input  t_ctrl_cmd  i_cmd,
    input  logic       i_m_ready,
    output t_dp_status o_status,
    output logic       o_m_valid,
    output logic       o_chip,
    output logic       o_epoch_start
);

    localparam int P_W = $clog2(CODE_LENGTH);

    t_prn           r_prn;
    t_lfsr          r_g1;
    t_lfsr          r_g2;
    logic [P_W-1:0] r_pos;
    logic [P_W-1:0] r_count;
    logic           r_aligned;
    logic           r_m_valid;
    logic           r_chip;
    logic           r_epoch;

    t_lfsr          n_g1;
    t_lfsr          n_g2;
    t_lfsr          w_delay;
    logic [P_W-1:0] w_steps;
    logic           w_fb1;
    logic           w_fb2;

    assign w_fb1 = r_g1[2] ^ r_g1[9];
    assign w_fb2 = r_g2[1] ^ r_g2[2] ^ r_g2[5] ^ r_g2[7] ^ r_g2[8] ^ r_g2[9];
    assign n_g1  = {r_g1[C_REG_WIDTH-2:0], w_fb1};
    assign n_g2  = {r_g2[C_REG_WIDTH-2:0], w_fb2};

    assign w_delay = g2_delay(r_prn);
    assign w_steps = (w_delay == '0) ? '0 : P_W'(CODE_LENGTH - int'(w_delay));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prn     <= C_PRN_WIDTH'(1);
            r_g1      <= '1;
            r_g2      <= '1;
            r_pos     <= '0;
            r_count   <= '0;
            r_aligned <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prn <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                r_g1      <= '1;
                r_g2      <= '1;
                r_pos     <= '0;
                r_count   <= w_steps;
                r_aligned <= 1'b1;
            end else if (i_cmd.step_g2) begin
                r_g2    <= n_g2;
                r_count <= r_count - P_W'(1);
            end else if (i_cmd.emit) begin
                r_g1 <= n_g1;
                r_g2 <= n_g2;
                if (r_pos == P_W'(CODE_LENGTH - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + P_W'(1);
                end
            end
            r_m_valid <= i_cmd.emit | (r_m_valid & ~i_m_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_chip  <= r_g1[C_REG_WIDTH-1] ^ r_g2[C_REG_WIDTH-1];
            r_epoch <= (r_pos == '0);
        end
    end

    assign o_status.aligned    = r_aligned;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.out_free   = ~r_m_valid | i_m_ready;
    assign o_m_valid           = r_m_valid;
    assign o_chip              = r_chip;
    assign o_epoch_start       = r_epoch;

endmodule

FILE: bench/gps_ca_code_generator_core_test.sv
// ----------------------------------------------------------------------------
// GPS C/A code generator core testbench
// Streams restart and plain items into the core and predicts every chip
// with an in-bench pair of G1/G2 shift registers. Each result is checked
// against the oldest prediction. Both stream sides idle at random. The PRN
// register is rewritten between phases while the core is drained.
// ----------------------------------------------------------------------------
module gps_ca_code_generator_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import gca_pkg::*;

    localparam logic ITEM_PLAIN   = 1'b0;
    localparam logic ITEM_RESTART = 1'b1;
    localparam int   MAX_WAIT     = 12;
    localparam int   MAX_REPORTS  = 10;

    typedef struct packed {
        logic chip;
        logic epoch_start;
    } t_code_chip;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [7:0] i_cfg_wdata   = '0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = '0;  // [0] restart, [7:1] zero
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;        // [0] chip, [7:1] zero
    logic [0:0] m_axis_tuser;        // [0] epoch_start

    logic       pending_items[$];
    t_code_chip expected_chips[$];

    t_prn  model_prn;
    t_lfsr g1_state;
    t_lfsr g2_state;
    int    chip_index;
    bit    model_aligned;

    bit src_taken = 1'b0;
    bit snk_taken = 1'b0;
    bit no_idle   = 1'b0;
    int src_gap   = 0;
    int snk_stall = 0;
    int error_count = 0;
    int ph;

    gps_ca_code_generator_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_lfsr g2_shift(input t_lfsr r);
        return {r[8:0], r[1] ^ r[2] ^ r[5] ^ r[7] ^ r[8] ^ r[9]};
    endfunction

    function automatic t_code_chip next_chip(input logic restart);
        t_code_chip res;
        t_lfsr      delay;
        int         steps;
        int         k;
        if (restart || !model_aligned) begin
            delay = '0;
            if (model_prn >= 1 && model_prn <= C_PRN_COUNT) begin
                delay = C_G2_DELAY[model_prn - 1];
            end
            steps = (delay == 0) ? 0 : C_CODE_LENGTH - delay;
            g1_state = '1;
            g2_state = '1;
            for (k = 0; k < steps; k++) begin
                g2_state = g2_shift(g2_state);
            end
            chip_index = 0;
            model_aligned = 1'b1;
        end
        res.chip = g1_state[9] ^ g2_state[9];
        res.epoch_start = (chip_index == 0);
        g1_state = {g1_state[8:0], g1_state[2] ^ g1_state[9]};
        g2_state = g2_shift(g2_state);
        chip_index = (chip_index + 1 >= C_CODE_LENGTH) ? 0 : chip_index + 1;
        return res;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_code_chip want;
        if (!i_rst_n) begin
            model_prn = 8'd1;
            g1_state = '1;
            g2_state = '1;
            chip_index = 0;
            model_aligned = 1'b0;
            src_taken = 1'b0;
            snk_taken = 1'b0;
        end else begin
            if (i_cfg_we) begin
                model_prn = i_cfg_wdata;
            end
            snk_taken = m_axis_tvalid && m_axis_tready;
            src_taken = s_axis_tvalid && s_axis_tready;
            if (snk_taken) begin
                if (expected_chips.size() == 0) begin
                    note_failure("result with no item pending");
                end else begin
                    want = expected_chips.pop_front();
                    if (m_axis_tdata[0] !== want.chip
                            || m_axis_tuser[0] !== want.epoch_start) begin
                        note_failure($sformatf("chip %b epoch %b, expected chip %b epoch %b",
                            m_axis_tdata[0], m_axis_tuser[0], want.chip, want.epoch_start));
                    end
                end
            end
            if (src_taken) begin
                expected_chips.push_back(next_chip(s_axis_tdata[0]));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap = draw_wait();
        end else if (src_taken || !s_axis_tvalid) begin
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {7'b0, pending_items.pop_front()};
                src_gap = draw_wait();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_stall = 0;
        end else begin
            if (snk_taken) begin
                snk_stall = draw_wait();
            end
            if (snk_stall > 0) begin
                snk_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_chips.size() != 0 || s_axis_tvalid) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic set_prn(input t_prn prn);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= prn;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pattern(input logic [15:0] bits, input int count);
        int k;
        for (k = count - 1; k >= 0; k--) begin
            pending_items.push_back(bits[k] ? ITEM_RESTART : ITEM_PLAIN);
        end
    endtask

    task automatic push_items(input int count, input int restart_pct);
        int k;
        for (k = 0; k < count; k++) begin
            pending_items.push_back(($urandom_range(0, 99) < restart_pct)
                ? ITEM_RESTART : ITEM_PLAIN);
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The first item after reset realigns even without a restart.
        push_pattern(16'b000100110, 9);
        set_prn(8'd210);
        push_pattern(16'b1000, 4);
        set_prn(8'd0);
        push_pattern(16'b100, 3);
        set_prn(8'd255);
        push_pattern(16'b10, 2);
        // A new PRN only takes effect at the next restart.
        set_prn(8'd211);
        push_pattern(16'b001, 3);
        set_prn(8'd37);
        no_idle = ($urandom_range(0, 1) == 0);
        push_pattern(16'b1, 1);
        push_items(1100, 0);
        for (ph = 0; ph < 6; ph++) begin
            set_prn((ph % 3 == 2) ? t_prn'($urandom_range(0, 255))
                                  : t_prn'($urandom_range(1, C_PRN_COUNT)));
            no_idle = ($urandom_range(0, 3) == 0);
            push_items(110, 5);
        end
        wait_drained();
        repeat (C_CODE_LENGTH + 80) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
